/* hdl/sf2_pkg.sv */
package sf2_pkg;

  localparam int TAPS     = 5;
  localparam int LINE_MAX = 2048;
  localparam int IN_BITS  = 8;
  localparam int OUT_BITS = 16;

  localparam int HALF  = TAPS / 2;
  localparam int SLOTS = TAPS - 1;

  localparam int CB     = 8;              // coefficient bits
  localparam int CFG_W  = 56;             // packed coefficient register
  localparam int COL_W  = $clog2(LINE_MAX);
  localparam int ROW_W  = 12;
  localparam int LW_W   = 12;
  localparam int WD_W   = $clog2(LINE_MAX + 1) + 1;
  localparam int K_W    = $clog2(HALF + 1);
  localparam int ROW_MAX = (1 << ROW_W) - 1;

  localparam int SW  = CB + $clog2(TAPS) + 1;              // sum of taps
  localparam int VW  = IN_BITS + 1 + CB + $clog2(TAPS);    // column sum
  localparam int HW  = VW + CB + $clog2(TAPS);             // window sum
  localparam int GW  = HW + CB;                            // after gain
  localparam int VAL_W = OUT_BITS + 1;
  localparam int MEM_W = SLOTS * IN_BITS;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    CFG_COEFFS_X     = 3'd0,
    CFG_COEFFS_Y     = 3'd1,
    CFG_GAIN         = 3'd2,
    CFG_SHIFT        = 3'd3,
    CFG_LINE_WIDTH   = 3'd4,
    CFG_BORDER_MODE  = 3'd5,
    CFG_BORDER_VALUE = 3'd6,
    CFG_OUTPUT_MODE  = 3'd7
  } sf2_cfg_idx_e;

  typedef enum logic [1:0] {
    OM_UNSIGNED = 2'd0,
    OM_SYMMETRIC = 2'd1,
    OM_ABSOLUTE = 2'd2
  } sf2_omode_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_VERT,
    B_WIN,
    B_HSUM,
    B_GAIN,
    B_PUT,
    B_NEXT
  } sf2_state_e;

  typedef struct packed {
    logic [CFG_W-1:0]  coeffs_x;
    logic [CFG_W-1:0]  coeffs_y;
    logic signed [7:0] gain;
    logic [4:0]        shift;
    logic [LW_W-1:0]   line_width;
    logic              border_mode;
    logic [7:0]        border_value;
    sf2_omode_e        output_mode;
  } sf2_cfg_t;

  typedef struct packed {
    logic               mode;
    logic [IN_BITS-1:0] pix;
    logic [COL_W-1:0]   col;
    logic               row0;
    logic               row_ok;
    logic               emit0;
    logic               row_end;
    logic               eof;
  } sf2_cmd_t;

  function automatic logic signed [CB-1:0] tap_of(input logic [CFG_W-1:0] c, input int i);
    return c[CB*i +: CB];
  endfunction

endpackage

/* hdl/sf2_fifo.sv */
module sf2_fifo import sf2_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sf2_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output sf2_cmd_t data_o,
  output logic     empty_o
);

  sf2_cmd_t         mem_q [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QAW:0]     cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

/* hdl/sf2_front.sv */
module sf2_front import sf2_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sf2_cfg_t           cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               mode_i,
  input  logic [IN_BITS-1:0] pixel_i,
  input  logic               eol_i,
  input  logic               eof_i,
  output logic               push_o,
  output sf2_cmd_t           cmd_o,
  input  logic               full_i
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [WD_W-1:0]  width;
  logic             row_end;

  always_comb begin
    width = WD_W'(cfg_i.line_width);
    if (width == '0) width = WD_W'(1);
    else if (width > WD_W'(LINE_MAX)) width = WD_W'(LINE_MAX);
  end

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;
  assign row_end = eol_i || eof_i || ((WD_W'(col_q) + WD_W'(1)) >= width);

  always_comb begin
    cmd_o.mode    = mode_i;
    cmd_o.pix     = pixel_i;
    cmd_o.col     = col_q;
    cmd_o.row0    = (row_q == '0);
    cmd_o.row_ok  = (row_q >= ROW_W'(HALF));
    cmd_o.emit0   = (row_q >= ROW_W'(HALF)) && (col_q >= COL_W'(HALF));
    cmd_o.row_end = row_end;
    cmd_o.eof     = eof_i;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (row_end) begin
        col_d = '0;
        if (eof_i) row_d = '0;
        else if (row_q != ROW_W'(ROW_MAX)) row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* hdl/sf2_back.sv */
module sf2_back import sf2_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sf2_cfg_t         cfg_i,
  input  logic             empty_i,
  input  sf2_cmd_t         cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VAL_W-1:0] out_value_o,
  output logic             out_row_last_o,
  output logic             out_frame_last_o
);

  sf2_state_e state_q, state_d;
  sf2_cmd_t   cmd_q;

  logic [MEM_W-1:0]        mem [LINE_MAX];
  logic [MEM_W-1:0]        rd_q, wdata;
  logic                    mem_re, mem_we, win_load, win_pad, h_load, g_load, out_load;

  logic signed [VW-1:0]    win_q [TAPS];
  logic signed [VW-1:0]    v_q, edge_q, v_c, edge_c;
  logic signed [HW-1:0]    h_q, h_c;
  logic signed [GW-1:0]    g_q, gs, sat;
  logic [K_W-1:0]          k_q;
  logic                    pad_emit;

  logic [IN_BITS-1:0]      slot [SLOTS];
  logic [IN_BITS-1:0]      p, fill, bval;
  logic signed [SW-1:0]    sumy;

  logic                    ov_q, rl_q, fl_q;
  logic [VAL_W-1:0]        val_q;

  localparam logic signed [GW-1:0] VMAX = GW'((1 << OUT_BITS) - 1);
  localparam logic signed [GW-1:0] SLIM = GW'((1 << (OUT_BITS - 1)) - 1);

  assign bval     = IN_BITS'(cfg_i.border_value);
  assign pad_emit = cmd_q.row_ok &&
                    ((COL_W+K_W)'(cmd_q.col) + (COL_W+K_W)'(k_q) + 1'b1
                      >= (COL_W+K_W)'(HALF));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!empty_i) state_d = B_VERT;
      B_VERT: state_d = B_WIN;
      B_WIN:  state_d = cmd_q.emit0 ? B_HSUM : B_NEXT;
      B_HSUM: state_d = B_GAIN;
      B_GAIN: state_d = B_PUT;
      B_PUT:  if (!ov_q || out_ready_i) state_d = B_NEXT;
      B_NEXT: begin
        if (cmd_q.row_end && (k_q < K_W'(HALF))) state_d = pad_emit ? B_HSUM : B_NEXT;
        else state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Control outputs of each state.
  always_comb begin
    pop_o    = 1'b0;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    win_load = 1'b0;
    win_pad  = 1'b0;
    h_load   = 1'b0;
    g_load   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      B_IDLE: begin
        pop_o  = !empty_i;
        mem_re = !empty_i;
      end
      B_VERT: mem_we = 1'b1;
      B_WIN:  win_load = 1'b1;
      B_HSUM: h_load = 1'b1;
      B_GAIN: g_load = 1'b1;
      B_PUT:  out_load = !ov_q || out_ready_i;
      B_NEXT: win_pad = cmd_q.row_end && (k_q < K_W'(HALF));
      default: ;
    endcase
  end

  // Vertical pass over the stored rows of one column.
  always_comb begin
    for (int j = 0; j < SLOTS; j++) slot[j] = rd_q[j*IN_BITS +: IN_BITS];
    if (cmd_q.mode) p = cfg_i.border_mode ? bval : slot[SLOTS-1];
    else p = cmd_q.pix;
    fill = cfg_i.border_mode ? bval : p;
    if (cmd_q.row0) begin
      for (int j = 0; j < SLOTS; j++) slot[j] = fill;
    end
    v_c  = '0;
    sumy = '0;
    for (int j = 0; j < SLOTS; j++) begin
      v_c  = v_c + VW'(tap_of(cfg_i.coeffs_y, j)) * VW'($signed({1'b0, slot[j]}));
      sumy = sumy + SW'(tap_of(cfg_i.coeffs_y, j));
    end
    v_c  = v_c + VW'(tap_of(cfg_i.coeffs_y, SLOTS)) * VW'($signed({1'b0, p}));
    sumy = sumy + SW'(tap_of(cfg_i.coeffs_y, SLOTS));
    edge_c = cfg_i.border_mode ? VW'($signed({1'b0, bval})) * VW'(sumy) : v_c;
    for (int j = 0; j < SLOTS - 1; j++) wdata[j*IN_BITS +: IN_BITS] = slot[j+1];
    wdata[(SLOTS-1)*IN_BITS +: IN_BITS] = p;
  end

  always_comb begin
    h_c = '0;
    for (int i = 0; i < TAPS; i++) begin
      h_c = h_c + HW'(tap_of(cfg_i.coeffs_x, i)) * HW'(win_q[i]);
    end
  end

  always_comb begin
    gs  = g_q >>> cfg_i.shift;
    sat = gs;
    case (cfg_i.output_mode)
      OM_SYMMETRIC: begin
        if (gs < -SLIM) sat = -SLIM;
        else if (gs > SLIM) sat = SLIM;
      end
      default: begin
        if ((cfg_i.output_mode == OM_ABSOLUTE) && (gs < 0)) sat = -gs;
        if (sat < 0) sat = '0;
        else if (sat > VMAX) sat = VMAX;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cmd_q.col] <= wdata;
    if (mem_re) rd_q <= mem[cmd_i.col];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (mem_we) begin
      v_q    <= v_c;
      edge_q <= edge_c;
    end
    if (win_load) begin
      // The first column of a row presets the window to the left border.
      for (int i = 0; i < TAPS - 1; i++) win_q[i] <= (cmd_q.col == '0) ? edge_q : win_q[i+1];
      win_q[TAPS-1] <= v_q;
    end else if (win_pad) begin
      for (int i = 0; i < TAPS - 1; i++) win_q[i] <= win_q[i+1];
      win_q[TAPS-1] <= edge_q;
    end
    if (h_load) h_q <= h_c;
    if (g_load) g_q <= GW'(h_q) * GW'(cfg_i.gain);
    if (out_load) begin
      val_q <= sat[VAL_W-1:0];
      rl_q  <= cmd_q.row_end && (k_q == K_W'(HALF));
      fl_q  <= cmd_q.row_end && cmd_q.eof && (k_q == K_W'(HALF));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (win_load) k_q <= '0;
      else if (win_pad) k_q <= k_q + 1'b1;
      if (out_load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o      = ov_q;
  assign out_value_o      = val_q;
  assign out_row_last_o   = rl_q;
  assign out_frame_last_o = fl_q;

  a_vert_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_VERT |-> $past(pop_o)) else $error("line read without a queued item");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= K_W'(HALF)) else $error("border count out of range");
  a_frame_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && fl_q) |-> rl_q) else $error("frame end without row end");
  a_put_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_PUT && ov_q && !out_ready_i) |=> state_q == B_PUT)
    else $error("result dropped while output stalled");

endmodule

/* hdl/separable_2d_filter.sv */
// Separable 5x5 convolution over a raster pixel stream.
// Pixels enter on the s_axis channel, one beat per pixel, row by row; tlast
// marks the end of a row and tuser carries the padding flag and the frame end.
// After the frame, two rows of padding beats flush the bottom rows. Results
// leave on m_axis, lagging the input by two rows and two columns; the beat
// that ends a row also yields the two pending columns on the right border.
// Registers are written through the cfg channel, which is always ready.
// A front stage counts rows and columns and files each beat in a two-entry
// queue; the back end reads the column from the line memory, forms the
// vertical sum, shifts the window and runs one shared filter, gain and
// saturation chain per result. The back end takes a new beat only once it is
// through with the last one, and the line memory read and the shared multiply
// chain set its pace. A result passes the vertical sum, window, filter, gain
// and output registers in turn.
// Reset clears the counters, the queue and the output valid flag and loads the
// register defaults; the line memory needs no clearing since the first row of
// each frame writes it. A stalled receiver holds the output register, the back
// end waits, and the queue fills before s_axis_tready falls.
module separable_2d_filter import sf2_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // pixel
  input  logic         s_axis_tlast,   // end_of_line
  input  logic [1:0]   s_axis_tuser,   // mode, end_of_frame
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,   // value
  output logic         m_axis_tlast,   // row_last
  output logic         m_axis_tuser,   // frame_last
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [55:0]  cfg_data_i
);

  sf2_cfg_t         cfg_q;
  sf2_cmd_t         push_cmd, head_cmd;
  logic             push, full, pop, empty;
  logic [VAL_W-1:0] value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeffs_x     <= '0;
      cfg_q.coeffs_y     <= '0;
      cfg_q.gain         <= 8'sd1;
      cfg_q.shift        <= '0;
      cfg_q.line_width   <= LW_W'(LINE_MAX);
      cfg_q.border_mode  <= 1'b0;
      cfg_q.border_value <= '0;
      cfg_q.output_mode  <= OM_UNSIGNED;
    end else if (cfg_valid_i) begin
      case (sf2_cfg_idx_e'(cfg_index_i))
        CFG_COEFFS_X:     cfg_q.coeffs_x     <= cfg_data_i;
        CFG_COEFFS_Y:     cfg_q.coeffs_y     <= cfg_data_i;
        CFG_GAIN:         cfg_q.gain         <= cfg_data_i[7:0];
        CFG_SHIFT:        cfg_q.shift        <= cfg_data_i[4:0];
        CFG_LINE_WIDTH:   cfg_q.line_width   <= cfg_data_i[LW_W-1:0];
        CFG_BORDER_MODE:  cfg_q.border_mode  <= cfg_data_i[0];
        CFG_BORDER_VALUE: cfg_q.border_value <= cfg_data_i[7:0];
        CFG_OUTPUT_MODE:  cfg_q.output_mode  <= sf2_omode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  sf2_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .mode_i  (s_axis_tuser[0]),
    .pixel_i (s_axis_tdata[IN_BITS-1:0]),
    .eol_i   (s_axis_tlast),
    .eof_i   (s_axis_tuser[1]),
    .push_o  (push),
    .cmd_o   (push_cmd),
    .full_i  (full)
  );

  sf2_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty)
  );

  sf2_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .empty_i          (empty),
    .cmd_i            (head_cmd),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_value_o      (value),
    .out_row_last_o   (m_axis_tlast),
    .out_frame_last_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{(24 - VAL_W){1'b0}}, value};

endmodule
